/* rtl/core/assert_macros.svh */
// Assertion macros used by the NMEA sentence framer to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge of aclk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition never holds on a rising edge of aclk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

/* rtl/core/nsf_pkg.sv */
// Package with types, constants and helper functions for the NMEA sentence framer.
package nsf_pkg;

    // One more than the longest sentence text, in bytes, including '$'
    localparam int MAX_SENTENCE = 128;
    localparam int LEN_W        = $clog2(MAX_SENTENCE);
    localparam int POS_W        = 7;

    localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(MAX_SENTENCE);

    // Character codes
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] CHAR_DEL    = 8'h7F;

    // Input action codes
    localparam logic ACTION_FEED    = 1'b0;
    localparam logic ACTION_DISCARD = 1'b1;

    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [3:0] {
        EV_NOISE     = 4'd0,
        EV_START     = 4'd1,
        EV_RESTART   = 4'd2,
        EV_BODY      = 4'd3,
        EV_ASTERISK  = 4'd4,
        EV_DIGIT     = 4'd5,
        EV_OK        = 4'd6,
        EV_CRC_ERROR = 4'd7,
        EV_CONTROL   = 4'd8,
        EV_OVERFLOW  = 4'd9,
        EV_BAD_DIGIT = 4'd10,
        EV_DISCARDED = 4'd11
    } event_t;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        event_t           event_res;
        logic             byte_valid;
        logic [7:0]       out_byte;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] sentence_length;
        logic [7:0]       computed_checksum;
        logic [7:0]       declared_checksum;
    } out_word_t;

    // Decode one hex digit in either case: {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

/* rtl/core/nsf_core.sv */
// Sentence state registers and the combinational framing step for one word.
module nsf_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  nsf_pkg::in_word_t item,
    output nsf_pkg::out_word_t result
);
    import nsf_pkg::*;

    logic       in_sentence_reg, in_sentence_next;
    logic       seen_ast_reg, seen_ast_next;
    len_t       text_len_reg, text_len_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] decl_reg, decl_next;
    logic       dcount_reg, dcount_next;

    logic [7:0] c;
    logic       fits;
    len_t       len_inc;
    logic [4:0] hex;
    logic [7:0] decl_shift;

    assign c          = item.data_byte;
    assign fits       = ({1'b0, text_len_reg} + 1'b1) < MAX_LEN;
    assign len_inc    = text_len_reg + 1'b1;
    assign hex        = hex_decode(c);
    assign decl_shift = {decl_reg[3:0], hex[3:0]};

    // Decide the event, the appended byte and the next sentence state
    always_comb begin
        in_sentence_next = in_sentence_reg;
        seen_ast_next    = seen_ast_reg;
        text_len_next    = text_len_reg;
        xor_next         = xor_reg;
        decl_next        = decl_reg;
        dcount_next      = dcount_reg;
        result           = '0;
        result.event_res = EV_NOISE;

        if (item.action == ACTION_DISCARD) begin
            in_sentence_next = 1'b0;
            seen_ast_next    = 1'b0;
            text_len_next    = '0;
            xor_next         = '0;
            decl_next        = '0;
            dcount_next      = 1'b0;
            result.event_res = EV_DISCARDED;
        end else if (c == CHAR_DOLLAR) begin
            // '$' always opens a fresh sentence
            in_sentence_next = 1'b1;
            seen_ast_next    = 1'b0;
            text_len_next    = len_t'(1);
            xor_next         = '0;
            decl_next        = '0;
            dcount_next      = 1'b0;
            result.event_res       = in_sentence_reg ? EV_RESTART : EV_START;
            result.byte_valid      = 1'b1;
            result.out_byte        = c;
            result.sentence_length = POS_W'(1);
        end else if (!in_sentence_reg) begin
            result.event_res = EV_NOISE;
        end else if (c < CTRL_LIMIT || c == CHAR_DEL || !fits ||
                     (seen_ast_reg && !hex[4])) begin
            // Abort: drop the sentence, report zeroed state
            in_sentence_next = 1'b0;
            seen_ast_next    = 1'b0;
            text_len_next    = '0;
            xor_next         = '0;
            decl_next        = '0;
            dcount_next      = 1'b0;
            if (c < CTRL_LIMIT || c == CHAR_DEL) begin
                result.event_res = EV_CONTROL;
            end else if (seen_ast_reg && !hex[4]) begin
                result.event_res = EV_BAD_DIGIT;
            end else begin
                result.event_res = EV_OVERFLOW;
            end
        end else if (!seen_ast_reg) begin
            // Body byte or the '*' that ends the body
            text_len_next = len_inc;
            if (c == CHAR_STAR) begin
                seen_ast_next    = 1'b1;
                result.event_res = EV_ASTERISK;
            end else begin
                xor_next         = xor_reg ^ c;
                result.event_res = EV_BODY;
            end
            result.byte_valid        = 1'b1;
            result.out_byte          = c;
            result.position          = POS_W'(text_len_reg);
            result.sentence_length   = POS_W'(len_inc);
            result.computed_checksum = xor_next;
            result.declared_checksum = decl_reg;
        end else if (!dcount_reg) begin
            // First checksum digit
            text_len_next            = len_inc;
            decl_next                = decl_shift;
            dcount_next              = 1'b1;
            result.event_res         = EV_DIGIT;
            result.byte_valid        = 1'b1;
            result.out_byte          = c;
            result.position          = POS_W'(text_len_reg);
            result.sentence_length   = POS_W'(len_inc);
            result.computed_checksum = xor_reg;
            result.declared_checksum = decl_shift;
        end else begin
            // Second digit closes the sentence
            in_sentence_next = 1'b0;
            seen_ast_next    = 1'b0;
            text_len_next    = '0;
            xor_next         = '0;
            decl_next        = '0;
            dcount_next      = 1'b0;
            result.event_res         = (decl_shift == xor_reg) ? EV_OK : EV_CRC_ERROR;
            result.byte_valid        = 1'b1;
            result.out_byte          = c;
            result.position          = POS_W'(text_len_reg);
            result.sentence_length   = POS_W'(len_inc);
            result.computed_checksum = xor_reg;
            result.declared_checksum = decl_shift;
        end
    end

    // Advance the sentence state on each processed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg <= 1'b0;
            seen_ast_reg    <= 1'b0;
            text_len_reg    <= '0;
            xor_reg         <= '0;
            decl_reg        <= '0;
            dcount_reg      <= 1'b0;
        end else if (step) begin
            in_sentence_reg <= in_sentence_next;
            seen_ast_reg    <= seen_ast_next;
            text_len_reg    <= text_len_next;
            xor_reg         <= xor_next;
            decl_reg        <= decl_next;
            dcount_reg      <= dcount_next;
        end
    end

endmodule

/* rtl/core/nmea_sentence_framer.sv */
// NMEA sentence framer: takes one byte or discard command per word and returns one
// result word carrying the framing event, the appended byte, its position, the
// text length and both checksums. Each word passes an input register, the
// combinational framing logic against the sentence state, and an output register,
// so the block accepts one word per cycle; throughput drops only while the output
// side holds m_ready low.
`include "assert_macros.svh"

module nmea_sentence_framer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  nsf_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output nsf_pkg::out_word_t m_data
);
    import nsf_pkg::*;

    logic      in_valid_reg;
    in_word_t  in_data_reg;
    logic      out_valid_reg;
    out_word_t out_data_reg;
    out_word_t step_result;
    logic      advance;
    logic      start_ev;
    logic      text_ev;
    logic      abort_ev;
    logic      cleared;
    logic      dollar_at_zero;

    // Move a word into the output register when it is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    nsf_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .result  (step_result)
    );

    // Hold the accepted input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    // Classify the outgoing event for the checks below
    assign start_ev = (m_data.event_res == EV_START) || (m_data.event_res == EV_RESTART);
    assign text_ev  = start_ev || (m_data.event_res == EV_BODY) ||
                      (m_data.event_res == EV_ASTERISK) || (m_data.event_res == EV_DIGIT) ||
                      (m_data.event_res == EV_OK) || (m_data.event_res == EV_CRC_ERROR);
    assign abort_ev = (m_data.event_res == EV_CONTROL) || (m_data.event_res == EV_OVERFLOW) ||
                      (m_data.event_res == EV_BAD_DIGIT) || (m_data.event_res == EV_DISCARDED);
    assign cleared  = (m_data.sentence_length == '0) && (m_data.computed_checksum == '0) &&
                      (m_data.declared_checksum == '0) && !m_data.byte_valid;
    assign dollar_at_zero = (m_data.position == '0) && (m_data.out_byte == CHAR_DOLLAR);

    // Appended bytes come only with events that keep text
    `ASSERT_CLK(a_byte_event, (m_valid && m_data.byte_valid) |-> text_ev, "byte appended on a non-text event")
    // Aborts report a cleared sentence
    `ASSERT_CLK(a_abort_clear, (m_valid && abort_ev) |-> cleared, "abort did not clear sentence")
    // A start puts '$' at position zero
    `ASSERT_CLK(a_start_pos, (m_valid && start_ev) |-> dollar_at_zero, "start not at position zero")
    // A word in the input register moves on when the output register is free
    `ASSERT_CLK(a_no_stall, (in_valid_reg && !out_valid_reg) |=> out_valid_reg, "input word not advanced")

endmodule

/* verif/tb_nmea_sentence_framer.sv */
// Self-checking testbench for the NMEA sentence framer: directed and random byte streams.
module tb_nmea_sentence_framer;
    timeunit 1ns;
    timeprecision 1ps;

    import nsf_pkg::*;

    localparam int RANDOM_WORDS = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_EVENTS   = 12;

    // Ways a generated sentence can deviate from a clean one
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_SUM,
        FLAW_FAULT
    } flaw_t;

    // Track the sentence state, predict each result word and check it on arrival
    class framer_scoreboard;
        bit           in_text;
        bit           after_star;
        bit           second_digit;
        int unsigned  text_len;
        logic [7:0]   body_xor;
        logic [7:0]   digit_value;
        out_word_t    pending_results[$];
        int           mismatches;
        int           event_count[NUM_EVENTS];

        function new();
            clear_text();
            mismatches = 0;
            foreach (event_count[i]) event_count[i] = 0;
        endfunction

        function void clear_text();
            in_text      = 1'b0;
            after_star   = 1'b0;
            second_digit = 1'b0;
            text_len     = 0;
            body_xor     = 8'h00;
            digit_value  = 8'h00;
        endfunction

        // Value of a hex digit in either case, -1 when the byte is no digit
        function int nibble_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            return -1;
        endfunction

        // Append a byte to the text and report the state after it
        function out_word_t placed_byte(logic [7:0] c, event_t ev);
            out_word_t r;
            r                   = '0;
            r.event_res         = ev;
            r.byte_valid        = 1'b1;
            r.out_byte          = c;
            r.position          = POS_W'(text_len);
            text_len++;
            r.sentence_length   = POS_W'(text_len);
            r.computed_checksum = body_xor;
            r.declared_checksum = digit_value;
            return r;
        endfunction

        function out_word_t frame_byte(in_word_t w);
            out_word_t  r;
            event_t     ev;
            logic [7:0] c;
            int         d;
            r = '0;
            c = w.data_byte;
            // Drop the partial sentence on command
            if (w.action == ACTION_DISCARD) begin
                clear_text();
                r.event_res = EV_DISCARDED;
                return r;
            end
            // Open a sentence, dropping any one in progress
            if (c == CHAR_DOLLAR) begin
                ev = in_text ? EV_RESTART : EV_START;
                clear_text();
                in_text = 1'b1;
                return placed_byte(c, ev);
            end
            if (!in_text) begin
                r.event_res = EV_NOISE;
                return r;
            end
            if (c < CTRL_LIMIT || c == CHAR_DEL) begin
                clear_text();
                r.event_res = EV_CONTROL;
                return r;
            end
            // Body up to and including the asterisk
            if (!after_star) begin
                ev = EV_BODY;
                if (c == CHAR_STAR) begin
                    after_star = 1'b1;
                    ev = EV_ASTERISK;
                end else begin
                    body_xor ^= c;
                end
                if (text_len + 1 >= MAX_SENTENCE) begin
                    clear_text();
                    r.event_res = EV_OVERFLOW;
                    return r;
                end
                return placed_byte(c, ev);
            end
            // Checksum digits
            d = nibble_of(c);
            if (d < 0) begin
                clear_text();
                r.event_res = EV_BAD_DIGIT;
                return r;
            end
            if (text_len + 1 >= MAX_SENTENCE) begin
                clear_text();
                r.event_res = EV_OVERFLOW;
                return r;
            end
            digit_value = {digit_value[3:0], 4'(d)};
            if (!second_digit) begin
                second_digit = 1'b1;
                return placed_byte(c, EV_DIGIT);
            end
            r = placed_byte(c, (digit_value == body_xor) ? EV_OK : EV_CRC_ERROR);
            clear_text();
            return r;
        endfunction

        function void note_word(in_word_t w);
            pending_results.push_back(frame_byte(w));
        endfunction

        function void check_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_word(out_word_t got);
            out_word_t exp;
            if (int'(got.event_res) < NUM_EVENTS) event_count[got.event_res]++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            check_field("event_res", exp.event_res, got.event_res);
            check_field("byte_valid", exp.byte_valid, got.byte_valid);
            check_field("out_byte", exp.out_byte, got.out_byte);
            check_field("position", exp.position, got.position);
            check_field("sentence_length", exp.sentence_length, got.sentence_length);
            check_field("computed_checksum", exp.computed_checksum, got.computed_checksum);
            check_field("declared_checksum", exp.declared_checksum, got.declared_checksum);
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    framer_scoreboard board = new();
    int  words_sent  = 0;
    int  cycle_count = 0;
    bit  source_burst = 1'b0;
    bit  sink_burst   = 1'b0;

    nmea_sentence_framer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Abort a run that hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, board.pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Hold one word on the input until accepted, after a random gap
    task automatic send_word(in_word_t w);
        int gap;
        gap = source_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        board.note_word(w);
        words_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word(in_word_t'{action: ACTION_FEED, data_byte: b});
    endtask

    task automatic send_discard();
        send_word(in_word_t'{action: ACTION_DISCARD, data_byte: 8'($urandom_range(0, 255))});
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Any byte that stays in the body: no control, no '$', no '*'
    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do c = 8'($urandom_range(32, 255));
        while (c == CHAR_DOLLAR || c == CHAR_STAR || c == CHAR_DEL);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
        if (n < 4'd10) return 8'("0") + 8'(n);
        return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    // Build a sentence with the given body length and flaw, then send it
    task automatic send_sentence(int body_len, flaw_t flaw);
        in_word_t   words[$];
        logic [7:0] sum;
        logic [7:0] c;
        int         at;
        sum = 8'h00;
        words.push_back(in_word_t'{action: ACTION_FEED, data_byte: CHAR_DOLLAR});
        for (int i = 0; i < body_len; i++) begin
            c = body_char();
            sum ^= c;
            words.push_back(in_word_t'{action: ACTION_FEED, data_byte: c});
        end
        words.push_back(in_word_t'{action: ACTION_FEED, data_byte: CHAR_STAR});
        if (flaw == FLAW_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
        words.push_back(in_word_t'{action: ACTION_FEED,
                                   data_byte: hex_char(sum[7:4], 1'($urandom_range(0, 1)))});
        words.push_back(in_word_t'{action: ACTION_FEED,
                                   data_byte: hex_char(sum[3:0], 1'($urandom_range(0, 1)))});
        // Break the sentence at a random point
        if (flaw == FLAW_FAULT) begin
            at = $urandom_range(1, words.size() - 1);
            case ($urandom_range(0, 4))
                0: begin
                    c = ($urandom_range(0, 5) == 0) ? CHAR_DEL : 8'($urandom_range(0, 31));
                    words.insert(at, in_word_t'{action: ACTION_FEED, data_byte: c});
                end
                1: words.insert(at, in_word_t'{action: ACTION_FEED, data_byte: CHAR_DOLLAR});
                2: words[at].data_byte = 8'($urandom_range(0, 255));
                3: words.insert(at, in_word_t'{action: ACTION_DISCARD,
                                               data_byte: 8'($urandom_range(0, 255))});
                default: words = words[0:at-1];
            endcase
        end
        foreach (words[i]) send_word(words[i]);
    endtask

    // Accept results after a random stall and check each one
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_word(m_data);
        end
    end

    initial begin
        int target;
        int pick;
        int seen;
        s_valid <= 1'b0;
        s_data  <= '0;
        m_ready <= 1'b0;
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle behavior: discard with nothing open, noise bytes
        send_discard();
        send_byte(8'hFF);
        send_byte(8'h00);
        // Clean sentences, hex digits in both cases, empty body
        send_text("$AB*03");
        send_text("$J*4a");
        send_text("$*00");
        send_byte(CHAR_DOLLAR);
        send_byte(8'hFF);
        send_text("*FF");
        // Checksum mismatch
        send_text("$J*4B");
        // Restart inside a sentence
        send_text("$A$A*41");
        // Control bytes in the body and after the asterisk
        send_text("$A");
        send_byte(8'h0D);
        send_text("$A*");
        send_byte(CHAR_DEL);
        // Non-hex digit
        send_text("$A*G");
        // Discard of an open sentence
        send_text("$A");
        send_discard();
        // Fill the text to its limit, overflow on the closing digit, then on a body byte
        send_sentence(124, FLAW_NONE);
        send_sentence(127, FLAW_NONE);

        // Random part: mostly sentences, some noise and broken ones
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            source_burst = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                send_sentence(($urandom_range(0, 14) == 0) ? $urandom_range(118, 130)
                                                           : $urandom_range(0, 16),
                              flaw_t'(($urandom_range(0, 9) < 6) ? FLAW_NONE
                                    : ($urandom_range(0, 1) ? FLAW_BAD_SUM : FLAW_FAULT)));
            end else if (pick < 87) begin
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 92) begin
                send_discard();
            end else begin
                send_byte(body_char());
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding results
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        seen = 0;
        foreach (board.event_count[i]) if (board.event_count[i] > 0) seen++;
        $display("Framed %0d words in %0d cycles: %0d clean sentences, %0d checksum errors",
                 words_sent, cycle_count, board.event_count[EV_OK],
                 board.event_count[EV_CRC_ERROR]);
        $display("Event codes observed: %0d of %0d, %0d mismatches",
                 seen, NUM_EVENTS, board.mismatches);
        if (board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
